[rtl/core/bfss_pkg.sv]
// Shared types, constants and register indexes for the shortest-path core.
`default_nettype none
package bfss_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERTEX_BITS = 6;
  localparam int INWEIGHT_BITS = 16;
  localparam int DIST_BITS = 32;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_TOTAL  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_VERTEX = 1'd1;

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [VERTEX_BITS-1:0]          from_vertex;
    logic [VERTEX_BITS-1:0]          to_vertex;
    logic signed [INWEIGHT_BITS-1:0] edge_weight;
    logic                            edge_present;
    logic                            last_item;
  } in_word_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0]      vertex_id;
    logic signed [DIST_BITS-1:0] path_distance;
    logic                        reachable;
    logic                        no_negative_cycle;
    logic                        last_result;
  } out_word_t;

  typedef struct packed {
    logic signed [DIST_BITS-1:0] cand;
    logic                        improves;
  } relax_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_FETCH,
    S_READ,
    S_RELAX,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/bfss_relax_alu.sv]
// Saturating add of tail distance and edge weight, compared against the head distance.
`default_nettype none
module bfss_relax_alu #(
  parameter int WEIGHT_BITS = bfss_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic signed [bfss_pkg::DIST_BITS-1:0] dist_tail,
  input  wire logic signed [bfss_pkg::DIST_BITS-1:0] dist_head,
  input  wire logic [WEIGHT_BITS-1:0]                 weight,
  input  wire logic                                   head_reached,
  output bfss_pkg::relax_res_t                        res
);

  logic signed [33:0] tail_x;
  logic signed [33:0] weight_x;
  logic signed [33:0] sum;
  logic               in_range;

  always_comb begin
    tail_x   = {{2{dist_tail[31]}}, dist_tail};
    weight_x = {{(34 - WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
    sum      = tail_x + weight_x;
    in_range = (sum[33:31] == 3'b000) || (sum[33:31] == 3'b111);
    if (in_range) begin
      res.cand = sum[31:0];
    end else if (sum[33]) begin
      res.cand = bfss_pkg::DIST_MIN;
    end else begin
      res.cand = bfss_pkg::DIST_MAX;
    end
    res.improves = !head_reached || (res.cand < dist_head);
  end

endmodule
`default_nettype wire

[rtl/core/bellman_ford_single_source_core.sv]
// Single-source shortest-path core: edge store, relaxation sequencer and result stream.
// After an edge word that is not the last, busy stays low and the next word may follow at once.
// A last word starts a run: an init state, then fetch, read and relax per edge for each of n-1
// rounds, then a check pass that ends at the first improving edge; one shared add/compare unit.
// Results then stream one per cycle, one for each of the n vertices, from the S_OUT state.
// Synchronous active-low reset clears control state; edge and distance memories need no clearing.
`default_nettype none
module bellman_ford_single_source_core #(
  parameter int MAX_VERTICES = bfss_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bfss_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = bfss_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bfss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [bfss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire bfss_pkg::in_word_t                  in_data,
  output logic                                     out_valid,
  output bfss_pkg::out_word_t                      out_data
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * bfss_pkg::VERTEX_BITS + WEIGHT_BITS;
  localparam int VB  = bfss_pkg::VERTEX_BITS;

  // configuration
  logic [6:0]    vertex_total_r;
  logic [VB-1:0] source_vertex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_total_r  <= 7'd1;
      source_vertex_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfss_pkg::CFG_VERTEX_TOTAL:  vertex_total_r  <= cfg_data;
        bfss_pkg::CFG_SOURCE_VERTEX: source_vertex_r <= cfg_data[VB-1:0];
        default: ;
      endcase
    end
  end

  // effective vertex count
  logic [15:0]    vt_w;
  logic [VCW-1:0] n_cnt;

  always_comb begin
    vt_w = 16'(vertex_total_r);
    if (vt_w == 16'd0) begin
      n_cnt = VCW'(1);
    end else if (vt_w > 16'(MAX_VERTICES)) begin
      n_cnt = VCW'(MAX_VERTICES);
    end else begin
      n_cnt = vt_w[VCW-1:0];
    end
  end

  // control registers
  bfss_pkg::state_t         state_r, state_nxt;
  logic [ECW-1:0]           edge_total_r, edge_total_nxt;
  logic                     overflow_r, overflow_nxt;
  logic [ECW-1:0]           idx_r, idx_nxt;
  logic [VCW-1:0]           round_r, round_nxt;
  logic [VCW-1:0]           vtx_r, vtx_nxt;
  logic                     check_r, check_nxt;
  logic                     clean_r, clean_nxt;
  logic [MAX_VERTICES-1:0]  reached_r, reached_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [VB-1:0]            pend_idx_r, pend_idx_nxt;
  logic                     pend_reach_r, pend_reach_nxt;
  logic                     pend_last_r, pend_last_nxt;

  // memories and their ports
  logic [EW-1:0]                           edge_mem [MAX_EDGES];
  logic [EW-1:0]                           edge_rd_r;
  logic                                    edge_we;
  logic [EW-1:0]                           edge_wd;
  logic signed [bfss_pkg::DIST_BITS-1:0]   dist_mem [MAX_VERTICES];
  logic signed [bfss_pkg::DIST_BITS-1:0]   dist_a_r;
  logic signed [bfss_pkg::DIST_BITS-1:0]   dist_b_r;
  logic                                    dist_we;
  logic [VAW-1:0]                          dist_wa;
  logic signed [bfss_pkg::DIST_BITS-1:0]   dist_wd;
  logic [VAW-1:0]                          dist_ra;
  logic [VAW-1:0]                          dist_rb;

  // decoded edge fields
  logic [15:0]             tail_w, head_w, src_w, n_w, vtx_w;
  logic [VAW-1:0]          tail_a, head_a, src_a, vtx_a;
  logic [WEIGHT_BITS-1:0]  edge_weight_q;
  logic [31:0]             raw_weight;
  logic                    edge_ok;
  logic                    edge_live;
  logic                    last_edge;
  bfss_pkg::relax_res_t    relax_res;

  always_comb begin
    tail_w        = 16'(edge_rd_r[EW-1 -: VB]);
    head_w        = 16'(edge_rd_r[EW-VB-1 -: VB]);
    edge_weight_q = edge_rd_r[WEIGHT_BITS-1:0];
    src_w         = 16'(source_vertex_r);
    n_w           = 16'(n_cnt);
    vtx_w         = 16'(vtx_r);
    tail_a        = tail_w[VAW-1:0];
    head_a        = head_w[VAW-1:0];
    src_a         = src_w[VAW-1:0];
    vtx_a         = vtx_w[VAW-1:0];
    raw_weight    = 32'($unsigned(in_data.edge_weight));
    edge_ok       = (tail_w < n_w) && (head_w < n_w);
    edge_live     = edge_ok && reached_r[tail_a];
    last_edge     = ((idx_r + ECW'(1)) == edge_total_r);
  end

  bfss_relax_alu #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .dist_tail    (dist_a_r),
    .dist_head    (dist_b_r),
    .weight       (edge_weight_q),
    .head_reached (reached_r[head_a]),
    .res          (relax_res)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    idx_nxt        = idx_r;
    round_nxt      = round_r;
    vtx_nxt        = vtx_r;
    check_nxt      = check_r;
    clean_nxt      = clean_r;
    reached_nxt    = reached_r;
    pend_valid_nxt = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    pend_reach_nxt = pend_reach_r;
    pend_last_nxt  = pend_last_r;
    edge_we        = 1'b0;
    edge_wd        = {in_data.from_vertex, in_data.to_vertex, raw_weight[WEIGHT_BITS-1:0]};
    dist_we        = 1'b0;
    dist_wa        = head_a;
    dist_wd        = relax_res.cand;
    dist_ra        = tail_a;
    dist_rb        = head_a;

    case (state_r)
      bfss_pkg::S_IDLE: begin
        if (start && !busy) begin
          if (in_data.edge_present) begin
            if (edge_total_r < ECW'(MAX_EDGES)) begin
              edge_we        = 1'b1;
              edge_total_nxt = edge_total_r + ECW'(1);
            end else begin
              overflow_nxt = 1'b1;
            end
          end
          if (in_data.last_item) begin
            state_nxt = bfss_pkg::S_INIT;
          end
        end
      end
      bfss_pkg::S_INIT: begin
        reached_nxt = '0;
        if (src_w < n_w) begin
          reached_nxt[src_a] = 1'b1;
        end
        dist_we   = 1'b1;
        dist_wa   = src_a;
        dist_wd   = '0;
        clean_nxt = 1'b1;
        idx_nxt   = '0;
        round_nxt = VCW'(1);
        vtx_nxt   = '0;
        check_nxt = (n_cnt == VCW'(1));
        if (edge_total_r == '0) begin
          state_nxt = bfss_pkg::S_OUT;
        end else begin
          state_nxt = bfss_pkg::S_FETCH;
        end
      end
      bfss_pkg::S_FETCH: begin
        state_nxt = bfss_pkg::S_READ;
      end
      bfss_pkg::S_READ: begin
        state_nxt = bfss_pkg::S_RELAX;
      end
      bfss_pkg::S_RELAX: begin
        state_nxt = bfss_pkg::S_FETCH;
        idx_nxt   = idx_r + ECW'(1);
        if (check_r) begin
          if (edge_live && relax_res.improves) begin
            clean_nxt = 1'b0;
            state_nxt = bfss_pkg::S_OUT;
          end else if (last_edge) begin
            state_nxt = bfss_pkg::S_OUT;
          end
        end else begin
          if (edge_live && relax_res.improves) begin
            dist_we             = 1'b1;
            reached_nxt[head_a] = 1'b1;
          end
          if (last_edge) begin
            idx_nxt = '0;
            if ((round_r + VCW'(1)) < n_cnt) begin
              round_nxt = round_r + VCW'(1);
            end else begin
              check_nxt = 1'b1;
            end
          end
        end
      end
      bfss_pkg::S_OUT: begin
        edge_total_nxt = '0;
        overflow_nxt   = 1'b0;
        dist_rb        = vtx_a;
        pend_valid_nxt = 1'b1;
        pend_idx_nxt   = vtx_w[VB-1:0];
        pend_reach_nxt = reached_r[vtx_a];
        pend_last_nxt  = ((vtx_r + VCW'(1)) == n_cnt);
        vtx_nxt        = vtx_r + VCW'(1);
        if ((vtx_r + VCW'(1)) == n_cnt) begin
          state_nxt = bfss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfss_pkg::S_IDLE;
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      idx_r        <= '0;
      round_r      <= '0;
      vtx_r        <= '0;
      check_r      <= 1'b0;
      clean_r      <= 1'b1;
      reached_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
      idx_r        <= idx_nxt;
      round_r      <= round_nxt;
      vtx_r        <= vtx_nxt;
      check_r      <= check_nxt;
      clean_r      <= clean_nxt;
      reached_r    <= reached_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    pend_reach_r <= pend_reach_nxt;
    pend_last_r  <= pend_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total_r[EAW-1:0]] <= edge_wd;
    end
    edge_rd_r <= edge_mem[idx_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_a_r <= dist_mem[dist_ra];
    dist_b_r <= dist_mem[dist_rb];
  end

  // result port
  always_comb begin
    busy                       = (state_r != bfss_pkg::S_IDLE) || pend_valid_r;
    out_valid                  = pend_valid_r;
    out_data.vertex_id         = pend_idx_r;
    out_data.path_distance     = pend_reach_r ? dist_b_r : '0;
    out_data.reachable         = pend_reach_r;
    out_data.no_negative_cycle = clean_r;
    out_data.last_result       = pend_last_r;
  end

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> (edge_total_r == ECW'(MAX_EDGES)))
    else $error("overflow flag set with room left in edge store");

  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_item) |=> (state_r == bfss_pkg::S_INIT))
    else $error("last word did not start a run");

  a_dist_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    dist_we |-> (state_r == bfss_pkg::S_INIT || state_r == bfss_pkg::S_RELAX))
    else $error("distance write outside init or relax");

  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_result) |=> out_valid)
    else $error("gap in result stream");

  a_stream_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_result) |=> !out_valid)
    else $error("result after final vertex");

endmodule
`default_nettype wire
